### hdl/pta_pkg.sv
// ----------------------------------------------------------------------------
// pta_pkg
// Shared types and constants of the trapezoidal PID controller: register
// indexes, the shared arithmetic unit's operation codes and command bundle.
// ----------------------------------------------------------------------------
package pta_pkg;

    localparam int DEF_DATA_WIDTH = 32;
    localparam int DEF_FRAC_BITS  = 16;

    // Sample period is unsigned Q0.16.
    localparam int PERIOD_FRAC = 16;
    localparam int PERIOD_W    = 16;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd328;

    // Multiplier digit width of the shared unit.
    localparam int DIGIT_W = 16;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP     = 3'd0,
        CFG_KI     = 3'd1,
        CFG_KD     = 3'd2,
        CFG_UPPER  = 3'd3,
        CFG_LOWER  = 3'd4,
        CFG_PERIOD = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_MUL_PERIOD = 2'd0,
        OP_MUL_GAIN   = 2'd1,
        OP_DIV        = 2'd2
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
        logic neg;
    } t_unit_cmd;

endpackage

### hdl/pid_trapezoid_antiwindup.sv
// ----------------------------------------------------------------------------
// pid_trapezoid_antiwindup
// Discrete PID controller with trapezoidal integration and integral clamp,
// signed fixed point, sequenced around one shared multiply/divide unit.
// ----------------------------------------------------------------------------
// A control update is accepted, sequenced through the shared unit and presented
// at o_out_valid, one item at a time; the divide in the shared unit is bit-serial.
// A clear item and the first update after reset or clear bypass the shared unit.
// Synchronous active-low reset restores register defaults and clears state.
module pid_trapezoid_antiwindup #(
    parameter int DATA_WIDTH = pta_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = pta_pkg::DEF_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pta_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [DATA_WIDTH-1:0]           i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic signed [DATA_WIDTH-1:0]    i_setpoint,
    input  logic signed [DATA_WIDTH-1:0]    i_measured,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [DATA_WIDTH-1:0]    o_drive,
    output logic                            o_computed
);
    import pta_pkg::*;

    localparam logic signed [DATA_WIDTH-1:0] Q_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] Q_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_PAIR,
        S_DIFF,
        S_INC_REQ,
        S_INT,
        S_P_REQ,
        S_I_REQ,
        S_PI,
        S_DRV,
        S_CL_HI,
        S_CL_LO,
        S_WAIT,
        S_OUT
    } t_state;

    t_state                        r_state;
    t_state                        r_after;

    logic signed [DATA_WIDTH-1:0]  r_kp;
    logic signed [DATA_WIDTH-1:0]  r_ki;
    logic signed [DATA_WIDTH-1:0]  r_kd;
    logic signed [DATA_WIDTH-1:0]  r_upper;
    logic signed [DATA_WIDTH-1:0]  r_lower;
    logic [PERIOD_W-1:0]           r_period;

    logic signed [DATA_WIDTH-1:0]  r_integral;
    logic signed [DATA_WIDTH-1:0]  r_prev;
    logic signed [DATA_WIDTH-1:0]  r_held;
    logic                          r_first;

    logic signed [DATA_WIDTH-1:0]  r_sp;
    logic signed [DATA_WIDTH-1:0]  r_meas;
    logic signed [DATA_WIDTH-1:0]  r_err;
    logic signed [DATA_WIDTH-1:0]  r_pair;
    logic signed [DATA_WIDTH-1:0]  r_diff;
    logic signed [DATA_WIDTH-1:0]  r_deriv;
    logic signed [DATA_WIDTH-1:0]  r_pterm;
    logic signed [DATA_WIDTH-1:0]  r_pi;
    logic                          r_computed;

    logic                          r_out_valid;
    logic signed [DATA_WIDTH-1:0]  r_out_drive;
    logic                          r_out_computed;

    // Saturating adder shared by every sum and difference.
    logic signed [DATA_WIDTH-1:0]  add_a;
    logic signed [DATA_WIDTH-1:0]  add_b;
    logic                          add_sub;
    logic signed [DATA_WIDTH:0]    sum_ext;
    logic signed [DATA_WIDTH-1:0]  sat_sum;

    // Operands and command of the shared multiply/divide unit.
    t_unit_cmd                     u_cmd;
    logic signed [DATA_WIDTH-1:0]  op_a;
    logic signed [DATA_WIDTH-1:0]  op_b;
    logic                          b_is_period;
    logic [PERIOD_W-1:0]           divisor;
    logic [DATA_WIDTH-1:0]         a_mag;
    logic [DATA_WIDTH-1:0]         b_mag;
    logic                          u_done;
    logic signed [DATA_WIDTH-1:0]  u_res;

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (r_state)
            S_ERR: begin
                add_a   = r_sp;
                add_b   = r_meas;
                add_sub = 1'b1;
            end
            S_PAIR: begin
                add_a = r_err;
                add_b = r_prev;
            end
            S_DIFF: begin
                add_a   = r_err;
                add_b   = r_prev;
                add_sub = 1'b1;
            end
            S_INT: begin
                add_a = r_integral;
                add_b = u_res;
            end
            S_PI: begin
                add_a = r_pterm;
                add_b = u_res;
            end
            S_DRV: begin
                add_a = r_pi;
                add_b = u_res;
            end
            default: ;
        endcase
        if (add_sub) begin
            sum_ext = {add_a[DATA_WIDTH-1], add_a} - {add_b[DATA_WIDTH-1], add_b};
        end else begin
            sum_ext = {add_a[DATA_WIDTH-1], add_a} + {add_b[DATA_WIDTH-1], add_b};
        end
        if (sum_ext[DATA_WIDTH] != sum_ext[DATA_WIDTH-1]) begin
            sat_sum = sum_ext[DATA_WIDTH] ? Q_MIN : Q_MAX;
        end else begin
            sat_sum = sum_ext[DATA_WIDTH-1:0];
        end
    end

    // A zero period divides by one.
    assign divisor = (r_period == '0) ? PERIOD_W'(1) : r_period;

    always_comb begin
        op_a        = '0;
        op_b        = '0;
        b_is_period = 1'b0;
        u_cmd.start = 1'b0;
        u_cmd.op    = OP_MUL_GAIN;
        case (r_state)
            S_INC_REQ: begin
                op_a        = r_pair;
                b_is_period = 1'b1;
                u_cmd.start = 1'b1;
                u_cmd.op    = OP_MUL_PERIOD;
            end
            S_INT: begin
                op_a        = r_diff;
                b_is_period = 1'b1;
                u_cmd.start = 1'b1;
                u_cmd.op    = OP_DIV;
            end
            S_P_REQ: begin
                op_a        = r_kp;
                op_b        = r_err;
                u_cmd.start = 1'b1;
            end
            S_I_REQ: begin
                op_a        = r_ki;
                op_b        = r_integral;
                u_cmd.start = 1'b1;
            end
            S_PI: begin
                op_a        = r_kd;
                op_b        = r_deriv;
                u_cmd.start = 1'b1;
            end
            default: ;
        endcase
        a_mag = op_a[DATA_WIDTH-1] ? DATA_WIDTH'(-op_a) : DATA_WIDTH'(op_a);
        if (b_is_period) begin
            b_mag = DATA_WIDTH'((u_cmd.op == OP_DIV) ? divisor : r_period);
        end else begin
            b_mag = op_b[DATA_WIDTH-1] ? DATA_WIDTH'(-op_b) : DATA_WIDTH'(op_b);
        end
        u_cmd.neg = op_a[DATA_WIDTH-1] ^ (op_b[DATA_WIDTH-1] & !b_is_period);
    end

    pta_muldiv #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (u_cmd),
        .i_a_mag  (a_mag),
        .i_b_mag  (b_mag),
        .o_done   (u_done),
        .o_result (u_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_kp        <= '0;
            r_ki        <= '0;
            r_kd        <= '0;
            r_upper     <= Q_MAX;
            r_lower     <= Q_MIN;
            r_period    <= PERIOD_RESET;
            r_integral  <= '0;
            r_prev      <= '0;
            r_held      <= '0;
            r_first     <= 1'b1;
            r_computed  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_KP:     r_kp     <= i_cfg_data;
                    CFG_KI:     r_ki     <= i_cfg_data;
                    CFG_KD:     r_kd     <= i_cfg_data;
                    CFG_UPPER:  r_upper  <= i_cfg_data;
                    CFG_LOWER:  r_lower  <= i_cfg_data;
                    CFG_PERIOD: r_period <= i_cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == S_OUT && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_sp   <= i_setpoint;
                        r_meas <= i_measured;
                        if (i_mode) begin
                            r_integral <= '0;
                            r_prev     <= '0;
                            r_held     <= '0;
                            r_first    <= 1'b1;
                            r_computed <= 1'b0;
                            r_state    <= S_OUT;
                        end else begin
                            r_state <= S_ERR;
                        end
                    end
                end
                S_ERR: begin
                    r_err <= sat_sum;
                    if (r_first) begin
                        // First update only records the error.
                        r_first    <= 1'b0;
                        r_prev     <= sat_sum;
                        r_computed <= 1'b0;
                        r_state    <= S_OUT;
                    end else begin
                        r_state <= S_PAIR;
                    end
                end
                S_PAIR: begin
                    r_pair  <= sat_sum;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_diff  <= sat_sum;
                    r_state <= S_INC_REQ;
                end
                S_INC_REQ: begin
                    r_after <= S_INT;
                    r_state <= S_WAIT;
                end
                S_INT: begin
                    r_integral <= sat_sum;
                    r_after    <= S_P_REQ;
                    r_state    <= S_WAIT;
                end
                S_P_REQ: begin
                    r_deriv <= u_res;
                    r_after <= S_I_REQ;
                    r_state <= S_WAIT;
                end
                S_I_REQ: begin
                    r_pterm <= u_res;
                    r_after <= S_PI;
                    r_state <= S_WAIT;
                end
                S_PI: begin
                    r_pi    <= sat_sum;
                    r_after <= S_DRV;
                    r_state <= S_WAIT;
                end
                S_DRV: begin
                    r_held  <= sat_sum;
                    r_state <= S_CL_HI;
                end
                S_CL_HI: begin
                    if (r_integral > r_upper) begin
                        r_integral <= r_upper;
                    end
                    r_state <= S_CL_LO;
                end
                S_CL_LO: begin
                    // Applied after the upper clamp, so crossed limits favor the lower one.
                    if (r_integral < r_lower) begin
                        r_integral <= r_lower;
                    end
                    r_prev     <= r_err;
                    r_computed <= 1'b1;
                    r_state    <= S_OUT;
                end
                S_WAIT: begin
                    if (u_done) begin
                        r_state <= r_after;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_drive    <= r_held;
                        r_out_computed <= r_computed;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_out_drive;
    assign o_computed  = r_out_computed;

endmodule

### hdl/pta_muldiv.sv
// ----------------------------------------------------------------------------
// pta_muldiv
// Shared iterative arithmetic unit. Multiplies two magnitudes one 16-bit
// digit per cycle with rounding, or divides a magnitude shifted up by the
// period fraction by a 16-bit divisor one quotient bit per cycle. The
// result is signed and saturated to the data width.
// ----------------------------------------------------------------------------
module pta_muldiv #(
    parameter int DATA_WIDTH = pta_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = pta_pkg::DEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pta_pkg::t_unit_cmd           i_cmd,
    input  logic [DATA_WIDTH-1:0]        i_a_mag,
    input  logic [DATA_WIDTH-1:0]        i_b_mag,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_result
);
    import pta_pkg::*;

    localparam int AW  = 2 * DATA_WIDTH;
    localparam int NW  = DATA_WIDTH + PERIOD_FRAC;
    localparam int NCH = (DATA_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int BW  = NCH * DIGIT_W;
    localparam int CW  = $clog2(NW);
    localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PW  = DATA_WIDTH + DIGIT_W;

    localparam logic signed [DATA_WIDTH-1:0] Q_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] Q_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL,
        U_DIV,
        U_FIN
    } t_ustate;

    t_ustate                       r_state;
    t_op                           r_op;
    logic                          r_neg;
    logic [DATA_WIDTH-1:0]         r_a;
    logic [BW-1:0]                 r_b;
    logic [PERIOD_W-1:0]           r_div;
    logic [PERIOD_W-1:0]           r_rem;
    logic [AW-1:0]                 r_acc;
    logic [CW-1:0]                 r_cnt;
    logic                          r_done;
    logic signed [DATA_WIDTH-1:0]  r_res;

    logic [PW-1:0]                 pp;
    logic [AW-1:0]                 pp_term;
    logic [PERIOD_W:0]             rem_sh;
    logic [PERIOD_W:0]             rem_diff;
    logic                          rem_ge;
    logic [AW-1:0]                 full;
    logic [DATA_WIDTH-1:0]         val;
    logic                          ovf;
    logic signed [DATA_WIDTH-1:0]  n_res;
    logic [AW-1:0]                 n_round;

    // One digit of the multiplier, placed at its weight.
    assign pp      = PW'(r_a) * PW'(r_b[DIGIT_W-1:0]);
    assign pp_term = AW'(pp) << (DIGIT_W * r_cnt[KW-1:0]);

    assign rem_sh   = {r_rem, r_acc[NW-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_div};
    assign rem_diff = rem_sh - {1'b0, r_div};

    // Rounding constant preloaded into the accumulator: half an output LSB.
    assign n_round = (i_cmd.op == OP_MUL_GAIN) ? (AW'(1) << (FRAC_BITS - 1))
                                               : (AW'(1) << PERIOD_FRAC);

    always_comb begin
        case (r_op)
            OP_MUL_GAIN:   full = r_acc >> FRAC_BITS;
            OP_MUL_PERIOD: full = r_acc >> (PERIOD_FRAC + 1);
            // Dividend bits shifted out above the quotient are not part of it.
            default:       full = AW'(r_acc[NW-1:0]);
        endcase
        val = full[DATA_WIDTH-1:0];
        ovf = (|full[AW-1:DATA_WIDTH]) ||
              (val[DATA_WIDTH-1] && (!r_neg || (|val[DATA_WIDTH-2:0])));
        if (ovf) begin
            n_res = r_neg ? Q_MIN : Q_MAX;
        end else begin
            n_res = r_neg ? -$signed(val) : $signed(val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            // The result is registered in U_FIN and flagged by r_done in the same cycle.
            r_done <= (r_state == U_FIN);
            unique case (r_state)
                U_IDLE: begin
                    if (i_cmd.start) begin
                        r_op  <= i_cmd.op;
                        r_neg <= i_cmd.neg;
                        r_a   <= i_a_mag;
                        r_b   <= BW'(i_b_mag);
                        r_div <= i_b_mag[PERIOD_W-1:0];
                        r_rem <= '0;
                        r_cnt <= '0;
                        if (i_cmd.op == OP_DIV) begin
                            r_acc   <= AW'({i_a_mag, {PERIOD_FRAC{1'b0}}});
                            r_state <= U_DIV;
                        end else begin
                            r_acc   <= n_round;
                            r_state <= U_MUL;
                        end
                    end
                end
                U_MUL: begin
                    r_acc <= r_acc + pp_term;
                    r_b   <= r_b >> DIGIT_W;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(NCH - 1)) begin
                        r_state <= U_FIN;
                    end
                end
                U_DIV: begin
                    r_rem <= rem_ge ? rem_diff[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
                    r_acc <= {r_acc[AW-2:0], rem_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(NW - 1)) begin
                        r_state <= U_FIN;
                    end
                end
                U_FIN: begin
                    r_res   <= n_res;
                    r_state <= U_IDLE;
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

### hdl/pta_checker.sv
// ----------------------------------------------------------------------------
// pta_checker
// Port-level checks of the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module pta_checker #(
    parameter int DATA_WIDTH = pta_pkg::DEF_DATA_WIDTH
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            i_mode,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic signed [DATA_WIDTH-1:0]    o_drive,
    input logic                            o_computed
);
    logic in_beat;

    assign in_beat = i_in_valid && !o_in_stall;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_drive) && $stable(o_computed))
        else $error("result beat changed while stalled");

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> o_in_stall)
        else $error("input accepted while an item is in progress");

    // A clear beat into an empty output produces a zero, not-computed result.
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_mode && !o_out_valid |=> ##1
            (o_out_valid && (o_drive == '0) && !o_computed))
        else $error("clear beat did not produce a zero result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind pid_trapezoid_antiwindup pta_checker #(.DATA_WIDTH(DATA_WIDTH)) u_pta_checker (.*);

### bench/pid_trapezoid_antiwindup_tb.sv
// ----------------------------------------------------------------------------
// pid_trapezoid_antiwindup_tb
// Drives setpoint/measured beats and clear beats into the PID controller under
// a range of gain, clamp and period settings. A bit-exact fixed-point model in
// the bench predicts every drive beat, and each one is checked in order. Both
// handshakes idle and stall in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module pid_trapezoid_antiwindup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pta_pkg::*;

    localparam int DW = DEF_DATA_WIDTH;
    localparam int FB = DEF_FRAC_BITS;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BEATS = 250;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam longint ONE = longint'(1) << FB;

    typedef logic signed [DW-1:0] q_t;

    localparam q_t Q_HI = {1'b0, {(DW-1){1'b1}}};
    localparam q_t Q_LO = {1'b1, {(DW-1){1'b0}}};
    localparam longint Q_HI_L = Q_HI;
    localparam longint Q_LO_L = Q_LO;

    typedef struct packed {
        logic mode;
        q_t   setpoint;
        q_t   measured;
    } loop_sample_t;

    typedef struct packed {
        q_t   drive;
        logic computed;
    } drive_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [DW-1:0] i_cfg_data = '0;
    logic         i_in_valid = 1'b0;
    logic         o_in_stall;
    logic         i_mode = 1'b0;
    q_t           i_setpoint = '0;
    q_t           i_measured = '0;
    logic         o_out_valid;
    logic         i_out_stall = 1'b0;
    q_t           o_drive;
    logic         o_computed;

    pid_trapezoid_antiwindup dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_setpoint  (i_setpoint),
        .i_measured  (i_measured),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_drive     (o_drive),
        .o_computed  (o_computed)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Controller model: configuration copy and runtime state.
    longint gain_p = 0, gain_i = 0, gain_d = 0;
    longint integ_hi = Q_HI_L, integ_lo = Q_LO_L;
    longint period_q = PERIOD_RESET;
    longint integ = 0, prev_err = 0, held_drive = 0;
    bit     first_pending = 1'b1;

    loop_sample_t loop_samples[$];
    drive_t       due_drives[$];

    int unsigned launched = 0;
    int unsigned samples_in = 0;
    int unsigned drives_out = 0;
    int unsigned new_drives = 0;
    int unsigned clears_seen = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_cnt = 0;
    int unsigned settings_cnt = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    bit          calm = 1'b0;

    function automatic longint clamp_q(longint v);
        if (v > Q_HI_L) return Q_HI_L;
        if (v < Q_LO_L) return Q_LO_L;
        return v;
    endfunction

    function automatic longint limit_mag(bit neg, bit [63:0] m);
        if (neg) return (m > 64'(Q_HI_L) + 1) ? Q_LO_L : -longint'(m);
        return (m > 64'(Q_HI_L)) ? Q_HI_L : longint'(m);
    endfunction

    // round(a * b / 2^shift), half away from zero, then saturated.
    function automatic longint scaled_product(longint a, longint b, int shift);
        bit        neg;
        bit [63:0] ua, ub, prod;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? -a : a;
        ub   = (b < 0) ? -b : b;
        prod = ua * ub + (64'd1 << (shift - 1));
        prod = prod >> shift;
        if (a == 0 || b == 0) neg = 1'b0;
        return limit_mag(neg, prod);
    endfunction

    // trunc(d * 2^16 / p), saturated. Magnitudes stay at or below 2^47.
    function automatic longint rate_of_change(longint d, longint p);
        bit [63:0] m;
        m = (d < 0) ? -d : d;
        return limit_mag(d < 0, (m << PERIOD_FRAC) / 64'(p));
    endfunction

    function automatic drive_t advance_loop(loop_sample_t s);
        longint err, pair, inc, diff, deriv, pi;
        drive_t r;
        r.computed = 1'b0;
        if (s.mode) begin
            integ = 0;
            prev_err = 0;
            held_drive = 0;
            first_pending = 1'b1;
        end else begin
            err = clamp_q(longint'($signed(s.setpoint)) - longint'($signed(s.measured)));
            if (first_pending) begin
                first_pending = 1'b0;
                prev_err = err;
            end else begin
                pair  = clamp_q(err + prev_err);
                inc   = scaled_product(pair, period_q, PERIOD_FRAC + 1);
                diff  = clamp_q(err - prev_err);
                deriv = rate_of_change(diff, (period_q == 0) ? 1 : period_q);
                integ = clamp_q(integ + inc);
                // The drive uses the integral before the anti-windup clamp.
                pi = clamp_q(scaled_product(gain_p, err, FB) +
                             scaled_product(gain_i, integ, FB));
                held_drive = clamp_q(pi + scaled_product(gain_d, deriv, FB));
                if (integ > integ_hi) integ = integ_hi;
                if (integ < integ_lo) integ = integ_lo;
                prev_err = err;
                r.computed = 1'b1;
            end
        end
        r.drive = q_t'(held_drive);
        return r;
    endfunction

    // Input driver: one sample at a time, with random gaps after acceptance.
    always @(negedge i_clk) begin
        loop_sample_t nxt;
        if (i_rst_n && launched == samples_in) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (loop_samples.size() > 0) begin
                nxt = loop_samples.pop_front();
                launched++;
                i_in_valid <= 1'b1;
                i_mode <= nxt.mode;
                i_setpoint <= nxt.setpoint;
                i_measured <= nxt.measured;
                if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 19);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure in random bursts.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!calm && i_rst_n && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 18);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: predicts on every input beat and checks every output beat.
    always @(posedge i_clk) begin
        drive_t want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                due_drives.push_back(advance_loop('{i_mode, i_setpoint, i_measured}));
                if (i_mode) clears_seen++;
                samples_in <= samples_in + 1;
            end
            if (o_out_valid && !i_out_stall) begin
                drives_out <= drives_out + 1;
                if (due_drives.size() == 0) begin
                    $error("drive: no beat expected, got %0d", o_drive);
                    fail_count++;
                end else begin
                    want = due_drives.pop_front();
                    if (o_drive !== want.drive) begin
                        $error("drive: expected %0d, got %0d", want.drive, o_drive);
                        fail_count++;
                    end
                    if (o_computed !== want.computed) begin
                        $error("computed: expected %0b, got %0b", want.computed,
                               o_computed);
                        fail_count++;
                    end
                    if (want.computed) new_drives++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("pid_trapezoid_antiwindup_tb: errors");
            $finish;
        end
    end

    function automatic void push_sample(bit mode, longint sp, longint ms);
        loop_samples.push_back('{mode, q_t'(sp), q_t'(ms)});
    endfunction

    function automatic q_t pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2: return q_t'($urandom);
            3: begin
                case ($urandom_range(0, 4))
                    0: return Q_HI;
                    1: return Q_LO;
                    2: return '0;
                    3: return '1;
                    default: return q_t'(1);
                endcase
            end
            8, 9: return q_t'(longint'($urandom_range(0, 1 << 28)) - (1 << 27));
            default: return q_t'(longint'($urandom_range(0, 1 << 23)) - (1 << 22));
        endcase
    endfunction

    // Gains within about +/-8.0, where the drive rarely saturates.
    function automatic q_t small_gain();
        return q_t'(longint'($urandom_range(0, 1 << 20)) - (1 << 19));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_KP:     gain_p = $signed(data);
            CFG_KI:     gain_i = $signed(data);
            CFG_KD:     gain_d = $signed(data);
            CFG_UPPER:  integ_hi = $signed(data);
            CFG_LOWER:  integ_lo = $signed(data);
            CFG_PERIOD: period_q = data[PERIOD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_quiet();
        do @(posedge i_clk);
        while (loop_samples.size() != 0 || launched != samples_in ||
               drives_out != samples_in);
    endtask

    task automatic set_phase(int p);
        q_t lim_a, lim_b, tmp;
        int per;
        case (p)
            1: begin
                write_reg(CFG_KP, q_t'(ONE + ONE / 2));
                write_reg(CFG_KI, q_t'(ONE / 4));
                write_reg(CFG_KD, q_t'(-ONE / 8));
                write_reg(CFG_UPPER, q_t'(50 * ONE));
                write_reg(CFG_LOWER, q_t'(-50 * ONE));
                write_reg(CFG_PERIOD, 32'd6554);
            end
            2: begin
                write_reg(CFG_KP, Q_HI);
                write_reg(CFG_KI, Q_LO);
                write_reg(CFG_KD, Q_HI);
                write_reg(CFG_UPPER, Q_HI);
                write_reg(CFG_LOWER, Q_LO);
                write_reg(CFG_PERIOD, 32'hFFFF_FFFF);
            end
            3: begin
                write_reg(CFG_KP, Q_LO);
                write_reg(CFG_KI, Q_HI);
                write_reg(CFG_KD, Q_LO);
                write_reg(CFG_UPPER, '0);
                write_reg(CFG_LOWER, '0);
                write_reg(CFG_PERIOD, 32'h5A5A_0001);
            end
            4: begin
                // A zero period: no integral growth, derivative over one LSB.
                write_reg(CFG_KP, small_gain());
                write_reg(CFG_KI, small_gain());
                write_reg(CFG_KD, q_t'(longint'($urandom_range(0, 64)) - 32));
                write_reg(CFG_UPPER, q_t'(20 * ONE));
                write_reg(CFG_LOWER, q_t'(-20 * ONE));
                write_reg(CFG_PERIOD, {16'($urandom), 16'd0});
            end
            5: begin
                // Crossed limits: the lower bound takes over.
                write_reg(CFG_KP, small_gain());
                write_reg(CFG_KI, small_gain());
                write_reg(CFG_KD, small_gain());
                write_reg(CFG_UPPER, q_t'(-5 * ONE));
                write_reg(CFG_LOWER, q_t'(5 * ONE));
                write_reg(CFG_PERIOD, 32'($urandom_range(1, 65535)));
            end
            default: begin
                write_reg(CFG_SPARE_LO, $urandom);
                write_reg(CFG_SPARE_HI, $urandom);
                write_reg(CFG_KP, ($urandom_range(0, 2) == 0) ? pick_value() : small_gain());
                write_reg(CFG_KI, ($urandom_range(0, 2) == 0) ? pick_value() : small_gain());
                write_reg(CFG_KD, ($urandom_range(0, 2) == 0) ? pick_value() : small_gain());
                lim_a = pick_value();
                lim_b = pick_value();
                if ((lim_a < lim_b) == ($urandom_range(0, 3) != 0)) begin
                    tmp = lim_a;
                    lim_a = lim_b;
                    lim_b = tmp;
                end
                write_reg(CFG_UPPER, lim_a);
                write_reg(CFG_LOWER, lim_b);
                per = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                  : $urandom_range(16, 8192);
                write_reg(CFG_PERIOD, {16'($urandom), 16'(per)});
            end
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_cnt++;
    endtask

    // Mostly a measurement that tracks a slowly changing setpoint, so the
    // integral winds up and reaches its clamps; some clears and wild values.
    task automatic fill_loop(int n);
        longint target, noise;
        int r;
        target = pick_value();
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 19);
            noise = longint'($urandom_range(0, 1 << 17)) - (1 << 16);
            if (r == 0) begin
                push_sample(1'b1, pick_value(), pick_value());
            end else begin
                if (r == 1) target = pick_value();
                if (r <= 3) push_sample(1'b0, pick_value(), pick_value());
                else push_sample(1'b0, target, clamp_q(target + noise));
            end
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults after reset: zero gains keep the drive at zero.
        push_sample(1'b0, 3 * ONE, ONE);
        push_sample(1'b0, 2 * ONE, 0);
        push_sample(1'b1, Q_HI_L, Q_LO_L);
        push_sample(1'b0, Q_HI_L, Q_LO_L);
        wait_quiet();

        set_phase(1);
        push_sample(1'b0, 0, 0);
        push_sample(1'b0, Q_HI_L, Q_LO_L);
        push_sample(1'b0, Q_LO_L, Q_HI_L);
        push_sample(1'b0, Q_LO_L, 0);
        push_sample(1'b0, Q_HI_L, -1);
        push_sample(1'b0, 1, 0);
        push_sample(1'b0, -1, 0);
        push_sample(1'b0, 0, 0);
        push_sample(1'b1, pick_value(), pick_value());
        push_sample(1'b1, Q_HI_L, Q_LO_L);
        push_sample(1'b0, 100 * ONE, 90 * ONE);
        push_sample(1'b0, 100 * ONE, 95 * ONE);
        push_sample(1'b0, 100 * ONE, 99 * ONE);
        push_sample(1'b0, -100 * ONE, 0);
        push_sample(1'b0, 0, Q_LO_L);
        push_sample(1'b0, Q_HI_L, Q_HI_L);
        wait_quiet();

        for (int p = 2; p < 2 + RANDOM_PHASES; p++) begin
            set_phase(p);
            if (p == 1 + RANDOM_PHASES) calm = 1'b1;
            fill_loop(PHASE_BEATS);
            wait_quiet();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (due_drives.size() != 0) begin
            $error("drive: %0d expected beats never arrived", due_drives.size());
            fail_count++;
        end

        $display("Sent %0d beats (%0d clears) under %0d register settings,",
                 samples_in, clears_seen, settings_cnt);
        $display("checked %0d drive beats, %0d of them freshly computed.",
                 drives_out, new_drives);
        if (fail_count == 0) begin
            $display("pid_trapezoid_antiwindup_tb: clean");
        end else begin
            $display("pid_trapezoid_antiwindup_tb: errors");
        end
        $finish;
    end

endmodule

### pid_trapezoid_antiwindup.f
hdl/pta_pkg.sv
hdl/pta_muldiv.sv
hdl/pid_trapezoid_antiwindup.sv
hdl/pta_checker.sv
bench/pid_trapezoid_antiwindup_tb.sv
